// File: hdl/cbpm_pkg.sv
package cbpm_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int FILE_BITS_DEF = 8;
  localparam int PAGE_BITS_DEF = 32;

  localparam int CFG_W     = 5;
  localparam int CFG_RESET = 16;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int PIN_W   = 8;
  localparam int PIN_MAX = 255;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_UNPIN   = 3'd1,
    CMD_ALLOC   = 3'd2,
    CMD_DISPOSE = 3'd3,
    CMD_FLUSH   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_NEW    = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOTPIN = 3'd3,
    ST_PINNED = 3'd4,
    ST_NOTRES = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SCAN_END,
    S_SW_RD,
    S_SW_EV,
    S_FL_RD,
    S_FL_EV,
    S_FL_NEXT,
    S_EMIT
  } state_e;

endpackage

// File: hdl/cbpm_store.sv
module cbpm_store #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 42
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/cbpm_apb.sv
module cbpm_apb
  import cbpm_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  output logic [$clog2(FRAMES+1)-1:0] n_o
);

  localparam int CNT_W = $clog2(FRAMES + 1);

  logic [CFG_W-1:0] frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= CFG_W'(CFG_RESET);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      frames_q <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : APB_DW'(frames_q);

  // zero acts as one frame, oversize as the whole pool
  always_comb begin
    if (frames_q == '0) begin
      n_o = CNT_W'(1);
    end else if (32'(frames_q) > FRAMES) begin
      n_o = CNT_W'(FRAMES);
    end else begin
      n_o = CNT_W'(frames_q);
    end
  end

endmodule

// File: hdl/cbpm_ctrl.sv
module cbpm_ctrl
  import cbpm_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int FILE_BITS = FILE_BITS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  parameter int IDX_W     = $clog2(FRAMES),
  parameter int CNT_W     = $clog2(FRAMES + 1),
  parameter int ENTRY_W   = FILE_BITS + PAGE_BITS + PIN_W + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CNT_W-1:0]     n_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           command_i,
  input  logic [FILE_BITS-1:0] file_id_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  logic                 mark_dirty_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [IDX_W-1:0]     frame_o,
  output logic                 fill_needed_o,
  output logic                 writeback_o,
  output logic [FILE_BITS-1:0] wb_file_o,
  output logic [PAGE_BITS-1:0] wb_page_o,
  output logic                 last_o,
  output logic                 mem_we_o,
  output logic [IDX_W-1:0]     mem_waddr_o,
  output logic [ENTRY_W-1:0]   mem_wdata_o,
  output logic [IDX_W-1:0]     mem_raddr_o,
  input  logic [ENTRY_W-1:0]   mem_rdata_i
);

  typedef struct packed {
    logic [FILE_BITS-1:0] file;
    logic [PAGE_BITS-1:0] page;
    logic [PIN_W-1:0]     pin;
    logic                 refb;
    logic                 dirty;
  } entry_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [IDX_W-1:0]     frame;
    logic                 fill;
    logic                 wb;
    logic [FILE_BITS-1:0] wbf;
    logic [PAGE_BITS-1:0] wbp;
    logic                 last;
  } res_t;

  state_e state_q, state_d, ret_q, ret_d;
  logic [2:0]           cmd_q, cmd_d;
  logic [FILE_BITS-1:0] file_q, file_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 md_q, md_d;
  logic [IDX_W-1:0]     idx_q, idx_d, hit_q, hit_d, hand_q, hand_d;
  logic                 found_q, found_d, free_q, free_d;
  entry_t               hit_e_q, hit_e_d;
  logic [FRAMES-1:0]    valid_q, valid_d;
  res_t                 res_q, res_d, out_q, out_d;
  logic                 ov_q, ov_d;

  entry_t             rd_e, wr_e;
  logic               cur_v, idx_last, slot_free;
  logic [IDX_W-1:0]   hand_nx;
  logic [CNT_W-1:0]   hand_inc;
  logic [PIN_W-1:0]   eff_pin;
  logic               eff_ref, eff_dirty;

  assign rd_e      = entry_t'(mem_rdata_i);
  assign idx_last  = (CNT_W'(idx_q) + CNT_W'(1)) == n_i;
  assign hand_inc  = CNT_W'(hand_q) + CNT_W'(1);
  assign hand_nx   = (hand_inc >= n_i) ? '0 : hand_inc[IDX_W-1:0];
  assign slot_free = !ov_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    cmd_d    = cmd_q;
    file_d   = file_q;
    page_d   = page_q;
    md_d     = md_q;
    idx_d    = idx_q;
    hit_d    = hit_q;
    hand_d   = hand_q;
    found_d  = found_q;
    free_d   = free_q;
    hit_e_d  = hit_e_q;
    valid_d  = valid_q;
    res_d    = res_q;
    out_d    = out_q;
    ov_d     = ov_q;
    wr_e     = hit_e_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = hit_q;
    mem_raddr_o = idx_q;
    in_ready_o  = 1'b0;

    // invalid frames read as cleared bookkeeping
    cur_v     = (state_q == S_SW_EV) ? valid_q[hand_q] : valid_q[idx_q];
    eff_pin   = cur_v ? rd_e.pin : '0;
    eff_ref   = cur_v && rd_e.refb;
    eff_dirty = cur_v && rd_e.dirty;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = command_i;
          file_d  = file_id_i;
          page_d  = page_number_i;
          md_d    = mark_dirty_i;
          idx_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          case (command_i)
            CMD_READ, CMD_UNPIN, CMD_ALLOC, CMD_DISPOSE: state_d = S_SCAN_RD;
            CMD_FLUSH: state_d = S_FL_RD;
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN_RD: begin
        mem_raddr_o = idx_q;
        state_d     = S_SCAN_EV;
      end

      S_SCAN_EV: begin
        if (eff_pin == '0) begin
          free_d = 1'b1;
        end
        if (cur_v && rd_e.file == file_q && rd_e.page == page_q &&
            cmd_q != CMD_ALLOC && !found_q) begin
          found_d = 1'b1;
          hit_d   = idx_q;
          hit_e_d = rd_e;
        end
        if (idx_last) begin
          state_d = S_SCAN_END;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_SCAN_RD;
        end
      end

      S_SCAN_END: begin
        res_d = '{status: ST_HIT, frame: hit_q, fill: 1'b0, wb: 1'b0,
                  wbf: '0, wbp: '0, last: 1'b1};
        ret_d   = S_IDLE;
        state_d = S_EMIT;
        case (cmd_q)
          CMD_UNPIN: begin
            if (!found_q) begin
              res_d.status = ST_NOTRES;
              res_d.frame  = '0;
            end else if (hit_e_q.pin == '0) begin
              res_d.status = ST_NOTPIN;
            end else begin
              wr_e.pin   = hit_e_q.pin - PIN_W'(1);
              wr_e.dirty = hit_e_q.dirty || md_q;
              mem_we_o   = 1'b1;
            end
          end
          CMD_DISPOSE: begin
            if (!found_q) begin
              res_d.status = ST_NOTRES;
              res_d.frame  = '0;
            end else begin
              valid_d[hit_q] = 1'b0;
              if (hit_e_q.dirty) begin
                res_d.wb  = 1'b1;
                res_d.wbf = hit_e_q.file;
                res_d.wbp = hit_e_q.page;
              end
            end
          end
          CMD_READ, CMD_ALLOC: begin
            if (cmd_q == CMD_READ && found_q) begin
              wr_e.refb = 1'b1;
              if (hit_e_q.pin != PIN_W'(PIN_MAX)) begin
                wr_e.pin = hit_e_q.pin + PIN_W'(1);
              end
              mem_we_o = 1'b1;
            end else if (!free_q) begin
              res_d.status = ST_FULL;
              res_d.frame  = '0;
            end else begin
              state_d = S_SW_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_SW_RD: begin
        hand_d      = hand_nx;
        mem_raddr_o = hand_nx;
        state_d     = S_SW_EV;
      end

      S_SW_EV: begin
        mem_waddr_o = hand_q;
        wr_e        = rd_e;
        if (eff_ref) begin
          wr_e.refb = 1'b0;
          mem_we_o  = 1'b1;
          state_d   = S_SW_RD;
        end else if (eff_pin != '0) begin
          state_d = S_SW_RD;
        end else begin
          wr_e = '{file: file_q, page: page_q, pin: PIN_W'(1), refb: 1'b1, dirty: 1'b0};
          mem_we_o        = 1'b1;
          valid_d[hand_q] = 1'b1;
          res_d = '{status: ST_NEW, frame: hand_q, fill: (cmd_q == CMD_READ),
                    wb: eff_dirty, wbf: eff_dirty ? rd_e.file : '0,
                    wbp: eff_dirty ? rd_e.page : '0, last: 1'b1};
          ret_d   = S_IDLE;
          state_d = S_EMIT;
        end
      end

      S_FL_RD: begin
        mem_raddr_o = idx_q;
        state_d     = S_FL_EV;
      end

      S_FL_EV: begin
        state_d = S_FL_NEXT;
        if (cur_v && rd_e.file == file_q) begin
          if (eff_pin != '0) begin
            res_d = '{status: ST_PINNED, frame: idx_q, fill: 1'b0, wb: 1'b0,
                      wbf: '0, wbp: '0, last: 1'b1};
            ret_d   = S_IDLE;
            state_d = S_EMIT;
          end else begin
            valid_d[idx_q] = 1'b0;
            if (eff_dirty) begin
              res_d = '{status: ST_HIT, frame: idx_q, fill: 1'b0, wb: 1'b1,
                        wbf: rd_e.file, wbp: rd_e.page, last: 1'b0};
              ret_d   = S_FL_NEXT;
              state_d = S_EMIT;
            end
          end
        end
      end

      S_FL_NEXT: begin
        if (idx_last) begin
          res_d = '{status: ST_HIT, frame: '0, fill: 1'b0, wb: 1'b0,
                    wbf: '0, wbp: '0, last: 1'b1};
          ret_d   = S_IDLE;
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_FL_RD;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_d   = res_q;
          ov_d    = 1'b1;
          state_d = ret_q;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign mem_wdata_o = wr_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      valid_q <= '0;
      hand_q  <= IDX_W'(FRAMES - 1);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      valid_q <= valid_d;
      hand_q  <= hand_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    file_q  <= file_d;
    page_q  <= page_d;
    md_q    <= md_d;
    idx_q   <= idx_d;
    hit_q   <= hit_d;
    found_q <= found_d;
    free_q  <= free_d;
    hit_e_q <= hit_e_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = out_q.status;
  assign frame_o       = out_q.frame;
  assign fill_needed_o = out_q.fill;
  assign writeback_o   = out_q.wb;
  assign wb_file_o     = out_q.wbf;
  assign wb_page_o     = out_q.wbp;
  assign last_o        = out_q.last;

endmodule

// File: hdl/clock_buffer_pool_manager.sv
// Clock-replacement buffer pool manager (tags and bookkeeping only). Frame tags,
// pin counts, reference and dirty bits live in one synchronous RAM; valid bits
// are flops. Scans read a frame, then evaluate it and write it back. With n frames
// in use, read, unpin, dispose and alloc scan all n frames; a read miss or alloc
// that found an unpinned frame then runs the clock sweep, at most 2n hand steps.
// Flush-file reads, evaluates and steps past each frame in turn, with one result per
// dirty frame dropped and a final one. Every result passes an output register; the
// next request is taken once the last result is in it.
// frames_in_use sits at APB address 0 (0 acts as 1, above FRAMES as FRAMES).
module clock_buffer_pool_manager
  import cbpm_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int FILE_BITS = FILE_BITS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                command_i,
  input  logic [FILE_BITS-1:0]      file_id_i,
  input  logic [PAGE_BITS-1:0]      page_number_i,
  input  logic                      mark_dirty_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                status_o,
  output logic [$clog2(FRAMES)-1:0] frame_o,
  output logic                      fill_needed_o,
  output logic                      writeback_o,
  output logic [FILE_BITS-1:0]      wb_file_o,
  output logic [PAGE_BITS-1:0]      wb_page_o,
  output logic                      last_o
);

  localparam int IDX_W   = $clog2(FRAMES);
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int ENTRY_W = FILE_BITS + PAGE_BITS + PIN_W + 2;

  logic [CNT_W-1:0]   n;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  cbpm_apb #(.FRAMES(FRAMES)) u_apb (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .n_o(n)
  );

  cbpm_store #(.DEPTH(FRAMES), .DATA_W(ENTRY_W)) u_store (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  cbpm_ctrl #(
    .FRAMES(FRAMES), .FILE_BITS(FILE_BITS), .PAGE_BITS(PAGE_BITS),
    .IDX_W(IDX_W), .CNT_W(CNT_W), .ENTRY_W(ENTRY_W)
  ) u_ctrl (
    .clk_i, .rst_ni, .n_i(n),
    .in_valid_i, .in_ready_o, .command_i, .file_id_i, .page_number_i, .mark_dirty_i,
    .out_valid_o, .out_ready_i, .status_o, .frame_o, .fill_needed_o, .writeback_o,
    .wb_file_o, .wb_page_o, .last_o,
    .mem_we_o(mem_we), .mem_waddr_o(mem_waddr), .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr), .mem_rdata_i(mem_rdata)
  );

  // an accepted known command makes the block go busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i <= CMD_FLUSH) |=> !in_ready_o)
    else $error("request accepted without going busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fill_needed_o) |-> (status_o == ST_NEW))
    else $error("fill flagged on a result without a new frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL || status_o == ST_NOTPIN ||
     status_o == ST_NOTRES || status_o == ST_PINNED)) |-> (last_o && !writeback_o))
    else $error("error result carries a write-back or is not final");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cbpm_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        fill;
    logic        wb;
    logic [7:0]  wb_file;
    logic [31:0] wb_page;
    logic        last;
  } pool_resp_t;

  class pool_scoreboard;
    bit          f_valid[16];
    logic [7:0]  f_file[16];
    logic [31:0] f_page[16];
    int unsigned f_pin[16];
    bit          f_ref[16];
    bit          f_dirty[16];
    int unsigned hand;
    int unsigned cfg_frames;
    pool_resp_t  pending[$];
    int          errors;

    function void reset_state();
      for (int i = 0; i < 16; i++) begin
        f_valid[i] = 0; f_file[i] = '0; f_page[i] = '0;
        f_pin[i] = 0; f_ref[i] = 0; f_dirty[i] = 0;
      end
      hand = 15;
      cfg_frames = 16;
      errors = 0;
    endfunction

    function int unsigned active_n();
      if (cfg_frames == 0) return 1;
      if (cfg_frames > 16) return 16;
      return cfg_frames;
    endfunction

    function void push_resp(logic [2:0] st, int unsigned fr, bit fill, bit wb,
                            logic [7:0] wf, logic [31:0] wp, bit last);
      pool_resp_t r;
      r.status = st; r.frame = fr[3:0]; r.fill = fill; r.wb = wb;
      r.wb_file = wf; r.wb_page = wp; r.last = last;
      pending.push_back(r);
    endfunction

    function int lookup(logic [7:0] f, logic [31:0] p, int unsigned n);
      for (int i = 0; i < n; i++)
        if (f_valid[i] && f_file[i] == f && f_page[i] == p) return i;
      return -1;
    endfunction

    function void clear_frame(int i);
      f_valid[i] = 0; f_pin[i] = 0; f_ref[i] = 0; f_dirty[i] = 0;
    endfunction

    function int clock_victim(int unsigned n);
      bit all_pinned;
      all_pinned = 1;
      for (int i = 0; i < n; i++) if (f_pin[i] == 0) all_pinned = 0;
      if (all_pinned) return -1;
      for (int s = 0; s <= 2 * n + 1; s++) begin
        hand = (hand + 1 >= n) ? 0 : hand + 1;
        if (f_ref[hand]) begin
          f_ref[hand] = 0;
          continue;
        end
        if (f_pin[hand] != 0) continue;
        return hand;
      end
      return -1;
    endfunction

    function void place_page(logic [7:0] f, logic [31:0] p, int unsigned n, bit fill);
      int v;
      v = clock_victim(n);
      if (v < 0) begin
        push_resp(ST_FULL, 0, 0, 0, '0, '0, 1);
        return;
      end
      if (f_valid[v] && f_dirty[v])
        push_resp(ST_NEW, v, fill, 1, f_file[v], f_page[v], 1);
      else
        push_resp(ST_NEW, v, fill, 0, '0, '0, 1);
      f_valid[v] = 1; f_file[v] = f; f_page[v] = p;
      f_pin[v] = 1; f_ref[v] = 1; f_dirty[v] = 0;
    endfunction

    function void note_request(logic [2:0] cmd, logic [7:0] f, logic [31:0] p, bit md);
      int unsigned n;
      int h;
      n = active_n();
      case (cmd)
        CMD_READ: begin
          h = lookup(f, p, n);
          if (h < 0) place_page(f, p, n, 1);
          else begin
            f_ref[h] = 1;
            if (f_pin[h] < PIN_MAX) f_pin[h]++;
            push_resp(ST_HIT, h, 0, 0, '0, '0, 1);
          end
        end
        CMD_UNPIN: begin
          h = lookup(f, p, n);
          if (h < 0) push_resp(ST_NOTRES, 0, 0, 0, '0, '0, 1);
          else if (f_pin[h] == 0) push_resp(ST_NOTPIN, h, 0, 0, '0, '0, 1);
          else begin
            f_pin[h]--;
            if (md) f_dirty[h] = 1;
            push_resp(ST_HIT, h, 0, 0, '0, '0, 1);
          end
        end
        CMD_ALLOC: place_page(f, p, n, 0);
        CMD_DISPOSE: begin
          h = lookup(f, p, n);
          if (h < 0) push_resp(ST_NOTRES, 0, 0, 0, '0, '0, 1);
          else begin
            if (f_dirty[h]) push_resp(ST_HIT, h, 0, 1, f_file[h], f_page[h], 1);
            else push_resp(ST_HIT, h, 0, 0, '0, '0, 1);
            clear_frame(h);
          end
        end
        CMD_FLUSH: begin
          for (int i = 0; i < n; i++) begin
            if (!f_valid[i] || f_file[i] != f) continue;
            if (f_pin[i] != 0) begin
              push_resp(ST_PINNED, i, 0, 0, '0, '0, 1);
              return;
            end
            if (f_dirty[i]) push_resp(ST_HIT, i, 0, 1, f_file[i], f_page[i], 0);
            clear_frame(i);
          end
          push_resp(ST_HIT, 0, 0, 0, '0, '0, 1);
        end
        default: ;
      endcase
    endfunction

    function void check_resp(pool_resp_t got);
      pool_resp_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [2:0] command_i = '0;
  logic [7:0] file_id_i = '0;
  logic [31:0] page_number_i = '0;
  logic mark_dirty_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [2:0] status_o;
  logic [3:0] frame_o;
  logic fill_needed_o, writeback_o, last_o;
  logic [7:0] wb_file_o;
  logic [31:0] wb_page_o;

  always #6 clk_i = ~clk_i;

  clock_buffer_pool_manager dut (.*);

  pool_scoreboard pool;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;
  logic [31:0] page_pool[8];

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        pool.check_resp({status_o, frame_o, fill_needed_o, writeback_o,
                         wb_file_o, wb_page_o, last_o});
      out_ready_i <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic cfg_write(int unsigned val);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    pool.cfg_frames = val & 5'h1f;
  endtask

  // valid stays up from one request to the next unless an idle gap is drawn
  task automatic send_req(logic [2:0] cmd, logic [7:0] f, logic [31:0] p, bit md);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1; command_i <= cmd; file_id_i <= f;
    page_number_i <= p; mark_dirty_i <= md;
    do @(posedge clk_i); while (!in_ready_o);
    pool.note_request(cmd, f, p, md);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pool.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic rand_req();
    int k;
    logic [2:0] cmd;
    logic [7:0] f;
    logic [31:0] p;
    k = $urandom_range(99);
    if (k < 35) cmd = CMD_READ;
    else if (k < 65) cmd = CMD_UNPIN;
    else if (k < 78) cmd = CMD_ALLOC;
    else if (k < 88) cmd = CMD_DISPOSE;
    else if (k < 97) cmd = CMD_FLUSH;
    else cmd = 3'($urandom_range(7, 5));
    f = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    p = ($urandom_range(9) == 0) ? $urandom : page_pool[$urandom_range(7)];
    send_req(cmd, f, p, 1'($urandom_range(1)));
  endtask

  initial begin
    pool = new();
    pool.reset_state();
    for (int i = 0; i < 8; i++) page_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed
    send_req(CMD_READ, 8'hff, 32'hffff_ffff, 0);
    send_req(CMD_READ, 8'hff, 32'hffff_ffff, 0);
    send_req(CMD_UNPIN, 8'hff, 32'hffff_ffff, 1);
    send_req(CMD_UNPIN, 8'hff, 32'hffff_ffff, 1);
    send_req(CMD_UNPIN, 8'hff, 32'hffff_ffff, 0);
    send_req(CMD_UNPIN, 8'h00, 32'h0, 0);
    send_req(CMD_ALLOC, 8'h00, 32'h0, 0);
    send_req(CMD_UNPIN, 8'h00, 32'h0, 1);
    send_req(CMD_DISPOSE, 8'h00, 32'h0, 0);
    send_req(CMD_DISPOSE, 8'h00, 32'h0, 0);
    send_req(CMD_FLUSH, 8'hff, 32'h0, 0);
    send_req(3'd7, 8'h1, 32'h1, 1);
    drain();
    cfg_write(1);
    send_req(CMD_READ, 8'h1, 32'h5, 0);
    send_req(CMD_READ, 8'h1, 32'h6, 0);
    send_req(CMD_UNPIN, 8'h1, 32'h5, 1);
    send_req(CMD_READ, 8'h1, 32'h6, 0);
    drain();
    cfg_write(0);
    send_req(CMD_ALLOC, 8'h2, 32'h9, 0);
    send_req(CMD_FLUSH, 8'h2, 32'h0, 0);
    drain();
    cfg_write(31);
    // random phases over frame counts and idling mixes
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      cfg_write(ph == 0 ? 16 : ph == 1 ? 2 : ph == 2 ? 4 : ph == 3 ? 16 : $urandom_range(31));
      send_idle_pct = (ph == 1 || ph == 4) ? 65 : (ph == 5) ? 10 : 0;
      stall_pct = (ph == 2 || ph == 4) ? 65 : (ph == 5) ? 10 : 0;
      if (ph == 3) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      repeat (32) rand_req();
    end
    drain();
    if (pool.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
